// ===== rtl/core/rtpl_pkg.sv =====
// package for the resonant two-pole lowpass filter
// types, register indexes and reset constants shared by every module of the block
// no dependencies
package rtpl_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int COEF_WIDTH      = 16;
  localparam int GAIN_WIDTH      = 24;
  localparam int CFG_INDEX_WIDTH = 8;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CUTOFF    = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RESONANCE = CFG_INDEX_WIDTH'(1);

  localparam logic [COEF_WIDTH-1:0] CUTOFF_RESET    = 16'd6554;
  localparam logic [COEF_WIDTH-1:0] RESONANCE_RESET = 16'd6554;

  // resonance + resonance / (1 - cutoff) for the reset registers
  localparam logic [31:0] GAIN_RESET_FULL = 32'(RESONANCE_RESET)
      + ((32'(RESONANCE_RESET) << 16) / (32'd65536 - 32'(CUTOFF_RESET)));
  localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = GAIN_RESET_FULL[GAIN_WIDTH-1:0];

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           block_last;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           clipped;
    logic                           block_last_out;
  } out_t;

  // datapath commands, at most one step per cycle
  typedef struct packed {
    logic capture;
    logic multiply;
    logic feedback;
    logic update_first;
    logic difference;
    logic update_second;
    logic load_out;
  } cmd_t;

endpackage

// ===== rtl/core/resonant_two_pole_lowpass.sv =====
// Resonant two-pole lowpass filter, top level.
// Input channel in_valid / in_stall carries in_data (sample_in Q1.15, block_last).
// Output channel out_valid / out_stall carries out_data (sample_out, clipped,
// block_last_out); exactly one result per accepted sample, in order.
// Config channel cfg_valid / cfg_ready writes cutoff (index 0) or resonance
// (index 1); other indexes are ignored. cfg_ready is always high.
// Each sample is walked from acceptance into the output register, one step per
// cycle but for a wait at the output step, by a sequencer that shares one split
// multiplier among the feedback, first-stage and second-stage products.
// A new sample is taken only after the previous one reaches the output register.
// A write to cutoff or resonance recomputes the feedback gain with a bit-serial
// divider; input transfers stall until it finishes.
// Reset (rst, synchronous) clears both stages and loads the reset cutoff,
// resonance and gain; no recompute is needed after reset.
// When the receiver stalls, the result holds in the output register; the next
// sample may still be taken and processed, and waits before its output step.
// depends on rtpl_pkg, rtpl_coef, rtpl_ctrl, rtpl_datapath
module resonant_two_pole_lowpass #(
  parameter int STAGE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  rtpl_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output rtpl_pkg::out_t                       out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rtpl_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [rtpl_pkg::COEF_WIDTH-1:0]      cfg_data
);
  import rtpl_pkg::*;

  logic [COEF_WIDTH-1:0] cutoff;
  logic [GAIN_WIDTH-1:0] gain;
  logic                  gain_busy;
  cmd_t                  cmd;

  rtpl_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cutoff    (cutoff),
    .gain      (gain),
    .busy      (gain_busy)
  );

  rtpl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .gain_busy (gain_busy),
    .cmd       (cmd)
  );

  rtpl_datapath #(
    .STAGE_WIDTH (STAGE_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cutoff   (cutoff),
    .gain     (gain),
    .cmd      (cmd),
    .out_data (out_data)
  );

  // one sample in flight: a transfer in is followed by a busy cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // no sample may use a gain that is still being computed
  a_no_accept_during_gain: assert property (@(posedge clk) disable iff (rst)
    gain_busy |-> in_stall)
    else $error("input accepted while gain recompute runs");

  a_write_starts_gain: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index == REG_CUTOFF || cfg_index == REG_RESONANCE))
    |=> gain_busy)
    else $error("register write did not start gain recompute");

  a_clip_full_scale: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.clipped)
    |-> (out_data.sample_out == SAMPLE_MAX || out_data.sample_out == SAMPLE_MIN))
    else $error("clipped result is not full scale");

endmodule

// ===== rtl/core/rtpl_coef.sv =====
// coefficient registers and feedback gain unit of the resonant lowpass filter
// holds cutoff and resonance, recomputes the gain with a bit-serial divider
// depends on rtpl_pkg
module rtpl_coef (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rtpl_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [rtpl_pkg::COEF_WIDTH-1:0]      cfg_data,
  output logic [rtpl_pkg::COEF_WIDTH-1:0]      cutoff,
  output logic [rtpl_pkg::GAIN_WIDTH-1:0]      gain,
  output logic                                 busy
);
  import rtpl_pkg::*;

  localparam int QUO_WIDTH = 2 * COEF_WIDTH;
  localparam int DEN_WIDTH = COEF_WIDTH + 1;
  localparam int CNT_WIDTH = $clog2(QUO_WIDTH + 1);
  localparam logic [CNT_WIDTH-1:0] DIV_STEPS = CNT_WIDTH'(QUO_WIDTH);

  logic [COEF_WIDTH-1:0] resonance;
  logic [CNT_WIDTH-1:0]  count;
  logic [DEN_WIDTH-1:0]  rem;
  logic [DEN_WIDTH-1:0]  den;
  logic [QUO_WIDTH-1:0]  quo;

  logic                  write;
  logic                  hit_cutoff;
  logic                  hit_resonance;
  logic [COEF_WIDTH-1:0] cutoff_next;
  logic [COEF_WIDTH-1:0] resonance_next;
  logic [DEN_WIDTH:0]    trial;
  logic                  trial_ge;
  logic [DEN_WIDTH-1:0]  rem_next;
  logic [QUO_WIDTH:0]    gain_sum;

  assign cfg_ready     = 1'b1;
  assign write         = cfg_valid && cfg_ready;
  assign hit_cutoff    = write && (cfg_index == REG_CUTOFF);
  assign hit_resonance = write && (cfg_index == REG_RESONANCE);

  assign cutoff_next    = hit_cutoff ? cfg_data : cutoff;
  assign resonance_next = hit_resonance ? cfg_data : resonance;

  // restoring division, one quotient bit per cycle
  assign trial    = {rem, quo[QUO_WIDTH-1]};
  assign trial_ge = trial >= {1'b0, den};
  assign rem_next = trial_ge ? DEN_WIDTH'(trial - {1'b0, den}) : trial[DEN_WIDTH-1:0];
  assign gain_sum = {1'b0, quo} + (QUO_WIDTH+1)'(resonance);

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff    <= CUTOFF_RESET;
      resonance <= RESONANCE_RESET;
      gain      <= GAIN_RESET;
      busy      <= 1'b0;
      count     <= '0;
    end else begin
      cutoff    <= cutoff_next;
      resonance <= resonance_next;
      if (hit_cutoff || hit_resonance) begin
        busy  <= 1'b1;
        count <= '0;
        rem   <= '0;
        quo   <= {resonance_next, {COEF_WIDTH{1'b0}}};
        den   <= DEN_WIDTH'(1 << COEF_WIDTH) - {1'b0, cutoff_next};
      end else if (busy) begin
        if (count == DIV_STEPS) begin
          busy <= 1'b0;
          if (|gain_sum[QUO_WIDTH:GAIN_WIDTH]) begin
            gain <= '1;
          end else begin
            gain <= gain_sum[GAIN_WIDTH-1:0];
          end
        end else begin
          rem   <= rem_next;
          quo   <= {quo[QUO_WIDTH-2:0], trial_ge};
          count <= count + CNT_WIDTH'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/core/rtpl_ctrl.sv =====
// sequencer of the resonant lowpass filter
// walks each sample through the datapath steps and owns both handshakes
// depends on rtpl_pkg
module rtpl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  logic               gain_busy,
  output rtpl_pkg::cmd_t     cmd
);
  import rtpl_pkg::*;

  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_MUL_FB     = 4'd1;
  localparam logic [3:0] ST_FEEDBACK   = 4'd2;
  localparam logic [3:0] ST_MUL_FIRST  = 4'd3;
  localparam logic [3:0] ST_UPD_FIRST  = 4'd4;
  localparam logic [3:0] ST_DIFF       = 4'd5;
  localparam logic [3:0] ST_MUL_SECOND = 4'd6;
  localparam logic [3:0] ST_UPD_SECOND = 4'd7;
  localparam logic [3:0] ST_OUTPUT     = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = gain_busy;
        if (in_valid && !gain_busy) begin
          cmd.capture = 1'b1;
          state_next  = ST_MUL_FB;
        end
      end
      ST_MUL_FB: begin
        cmd.multiply = 1'b1;
        state_next   = ST_FEEDBACK;
      end
      ST_FEEDBACK: begin
        cmd.feedback = 1'b1;
        state_next   = ST_MUL_FIRST;
      end
      ST_MUL_FIRST: begin
        cmd.multiply = 1'b1;
        state_next   = ST_UPD_FIRST;
      end
      ST_UPD_FIRST: begin
        cmd.update_first = 1'b1;
        state_next       = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.difference = 1'b1;
        state_next     = ST_MUL_SECOND;
      end
      ST_MUL_SECOND: begin
        cmd.multiply = 1'b1;
        state_next   = ST_UPD_SECOND;
      end
      ST_UPD_SECOND: begin
        cmd.update_second = 1'b1;
        state_next        = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        // wait until the output register is free or being emptied
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/rtpl_datapath.sv =====
// datapath of the resonant lowpass filter
// two saturating stages, one split multiplier shared by all three products, output clip
// depends on rtpl_pkg
module rtpl_datapath #(
  parameter int STAGE_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rtpl_pkg::in_t                    in_data,
  input  logic [rtpl_pkg::COEF_WIDTH-1:0]  cutoff,
  input  logic [rtpl_pkg::GAIN_WIDTH-1:0]  gain,
  input  rtpl_pkg::cmd_t                   cmd,
  output rtpl_pkg::out_t                   out_data
);
  import rtpl_pkg::*;

  localparam int SH  = STAGE_WIDTH - SAMPLE_WIDTH - 5;
  localparam int OPW = STAGE_WIDTH + 10;
  localparam int LOW = 24;
  localparam int HIW = OPW - LOW;
  localparam int PW  = OPW + GAIN_WIDTH + 1;
  localparam int YW  = (SH >= 0) ? STAGE_WIDTH : SAMPLE_WIDTH + 5;

  logic signed [STAGE_WIDTH-1:0]     first_stage;
  logic signed [STAGE_WIDTH-1:0]     second_stage;
  logic signed [STAGE_WIDTH-1:0]     xs;
  logic                              last;
  logic signed [OPW-1:0]             opnd;
  logic [GAIN_WIDTH-1:0]             coef;
  logic [LOW+GAIN_WIDTH-1:0]         plo;
  logic signed [HIW+GAIN_WIDTH:0]    phi;

  logic signed [STAGE_WIDTH-1:0]     xs_conv;
  logic signed [PW-1:0]              prod;
  logic signed [OPW-1:0]             qv;
  logic signed [OPW-1:0]             stage_diff;
  logic signed [YW-1:0]              y;
  logic                              clip;
  logic signed [SAMPLE_WIDTH-1:0]    y_clamped;

  function automatic logic signed [STAGE_WIDTH-1:0] sat_stage(input logic signed [OPW-1:0] x);
    logic same;
    same = (&x[OPW-1:STAGE_WIDTH-1]) || !(|x[OPW-1:STAGE_WIDTH-1]);
    if (same) begin
      return x[STAGE_WIDTH-1:0];
    end else if (x[OPW-1]) begin
      return {1'b1, {(STAGE_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(STAGE_WIDTH-1){1'b1}}};
    end
  endfunction

  // sample to stage format and back
  if (SH >= 0) begin : g_scale_up
    assign xs_conv = STAGE_WIDTH'(in_data.sample_in) <<< SH;
    assign y       = second_stage >>> SH;
  end else begin : g_scale_down
    assign xs_conv = STAGE_WIDTH'(in_data.sample_in >>> (-SH));
    assign y       = {second_stage, {(-SH){1'b0}}};
  end

  // reassemble the split product, then floor by 2^16
  assign prod       = (PW'(phi) <<< LOW) + $signed(PW'(plo));
  assign qv         = OPW'(prod >>> 16);
  assign stage_diff = OPW'(first_stage) - OPW'(second_stage);

  assign clip      = !((&y[YW-1:SAMPLE_WIDTH-1]) || !(|y[YW-1:SAMPLE_WIDTH-1]));
  assign y_clamped = clip ? (y[YW-1] ? SAMPLE_MIN : SAMPLE_MAX) : y[SAMPLE_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      first_stage  <= '0;
      second_stage <= '0;
    end else begin
      if (cmd.update_first) begin
        first_stage <= sat_stage(OPW'(first_stage) + qv);
      end
      if (cmd.update_second) begin
        second_stage <= sat_stage(OPW'(second_stage) + qv);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xs   <= xs_conv;
      last <= in_data.block_last;
      opnd <= stage_diff;
      coef <= gain;
    end
    if (cmd.feedback) begin
      opnd <= OPW'(xs) - OPW'(first_stage) + qv;
      coef <= GAIN_WIDTH'(cutoff);
    end
    if (cmd.difference) begin
      opnd <= stage_diff;
    end
    if (cmd.multiply) begin
      plo <= opnd[LOW-1:0] * coef;
      phi <= $signed(opnd[OPW-1:LOW]) * $signed({1'b0, coef});
    end
    if (cmd.load_out) begin
      out_data.sample_out     <= y_clamped;
      out_data.clipped        <= clip;
      out_data.block_last_out <= last;
    end
  end

endmodule

// ===== sim/resonant_two_pole_lowpass_checker.sv =====
`timescale 1ns / 1ps
// checker for the resonant two-pole lowpass filter: tracks register writes, predicts each
// filtered sample from the accepted inputs and compares it with the output transfers
// depends on rtpl_pkg
module resonant_two_pole_lowpass_checker
  import rtpl_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  in_t                        in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  out_t                       out_data,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [COEF_WIDTH-1:0]      cfg_data,
  output int                         mismatches,
  output int                         pending_results
);

  localparam int STAGE_BITS  = 32;
  localparam int STAGE_SHIFT = STAGE_BITS - SAMPLE_WIDTH - 5;
  localparam longint STAGE_MAX = longint'((64'd1 << (STAGE_BITS - 1)) - 64'd1);
  localparam longint STAGE_MIN = -STAGE_MAX - 1;
  localparam logic [GAIN_WIDTH-1:0] GAIN_CEIL = '1;
  localparam int REPORT_LIMIT = 10;

  logic [COEF_WIDTH-1:0] cutoff_reg;
  logic [COEF_WIDTH-1:0] resonance_reg;
  logic [GAIN_WIDTH-1:0] gain_reg;
  longint                stage_one;
  longint                stage_two;
  out_t                  filtered_q[$];
  int                    bad_count = 0;

  function automatic logic [GAIN_WIDTH-1:0] feedback_gain_of(input logic [COEF_WIDTH-1:0] fc,
                                                             input logic [COEF_WIDTH-1:0] res);
    longint unsigned g;
    g = 64'(res) + ((64'(res) << 16) / (64'd65536 - 64'(fc)));
    return (g > 64'(GAIN_CEIL)) ? GAIN_CEIL : g[GAIN_WIDTH-1:0];
  endfunction

  function automatic longint clamp_stage(input longint v);
    if (v > STAGE_MAX) return STAGE_MAX;
    if (v < STAGE_MIN) return STAGE_MIN;
    return v;
  endfunction

  // advances both stages by one sample and returns the filtered output
  function automatic out_t filter_step(input in_t s);
    longint xs;
    longint fb;
    longint t;
    longint y;
    out_t   r;
    xs = longint'($signed(s.sample_in)) * (longint'(1) <<< STAGE_SHIFT);
    fb = ((stage_one - stage_two) * longint'(gain_reg)) >>> 16;
    t = xs - stage_one + fb;
    stage_one = clamp_stage(stage_one + ((t * longint'(cutoff_reg)) >>> 16));
    stage_two = clamp_stage(stage_two +
                            (((stage_one - stage_two) * longint'(cutoff_reg)) >>> 16));
    y = stage_two >>> STAGE_SHIFT;
    r.clipped = 1'b0;
    // exactly minus one passes without a clip
    if (y > longint'(SAMPLE_MAX)) begin
      y = longint'(SAMPLE_MAX);
      r.clipped = 1'b1;
    end else if (y < longint'(SAMPLE_MIN)) begin
      y = longint'(SAMPLE_MIN);
      r.clipped = 1'b1;
    end
    r.sample_out = y[SAMPLE_WIDTH-1:0];
    r.block_last_out = s.block_last;
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      cutoff_reg = CUTOFF_RESET;
      resonance_reg = RESONANCE_RESET;
      gain_reg = feedback_gain_of(CUTOFF_RESET, RESONANCE_RESET);
      stage_one = 0;
      stage_two = 0;
      filtered_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CUTOFF:    cutoff_reg = cfg_data;
          REG_RESONANCE: resonance_reg = cfg_data;
          default: ;
        endcase
        gain_reg = feedback_gain_of(cutoff_reg, resonance_reg);
      end
      // outputs first so a transfer never pairs with an input of the same edge
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          bad_count++;
          if (bad_count <= REPORT_LIMIT)
            $display("%0t: output transfer with no sample pending: sample %0d clip %0b last %0b",
                     $time, out_data.sample_out, out_data.clipped, out_data.block_last_out);
        end else begin
          want = filtered_q.pop_front();
          if (want.sample_out !== out_data.sample_out || want.clipped !== out_data.clipped ||
              want.block_last_out !== out_data.block_last_out) begin
            bad_count++;
            if (bad_count <= REPORT_LIMIT)
              $display("%0t: expected sample %0d clip %0b last %0b, got sample %0d clip %0b last %0b",
                       $time, want.sample_out, want.clipped, want.block_last_out,
                       out_data.sample_out, out_data.clipped, out_data.block_last_out);
          end
        end
      end
      if (in_valid && !in_stall)
        filtered_q.push_back(filter_step(in_data));
    end
    mismatches <= bad_count;
    pending_results <= filtered_q.size();
  end

endmodule

// ===== sim/resonant_two_pole_lowpass_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the resonant two-pole lowpass filter: clock, reset, sample and
// register stimulus, receiver stalls, watchdog and verdict
// depends on rtpl_pkg, resonant_two_pole_lowpass and resonant_two_pole_lowpass_checker
module resonant_two_pole_lowpass_tb;
  import rtpl_pkg::*;

  localparam int SETTLE_CYCLES   = 48;
  localparam int DRAIN_CYCLES    = 20;
  localparam int IDLE_LIMIT      = 2000;
  localparam int DIRECTED_ITEMS  = 22;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 188;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_FIRST = CFG_INDEX_WIDTH'(2);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_TOP   = '1;
  localparam logic [COEF_WIDTH-1:0] CUTOFF_STEPS [5]    = '{16'd64880, 16'd0, 16'hFFFF,
                                                            16'd64880, 16'd1};
  localparam logic [COEF_WIDTH-1:0] RESONANCE_STEPS [5] = '{16'd57672, 16'd0, 16'hFFFF,
                                                            16'd0, 16'hFFFF};

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  in_t                        in_data = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  out_t                       out_data;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [COEF_WIDTH-1:0]      cfg_data = '0;
  int                         mismatches;
  int                         pending_results;

  int stall_mode = 0;
  int stall_left = 0;
  int gap_mode = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  always #4 clk = ~clk;

  resonant_two_pole_lowpass dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  resonant_two_pole_lowpass_checker filter_monitor (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending_results (pending_results)
  );

  // receiver: none, stalls on scattered random cycles, or alternating runs of stall and flow
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_stall <= ~out_stall;
          stall_left <= out_stall ? $urandom_range(0, 12) : $urandom_range(0, 20);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // one sample transfer; bursts end in a random gap unless gaps are off
  task automatic push_sample(input in_t s);
    if (burst_left == 0) burst_left = $urandom_range(1, 16);
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left == 0 && gap_mode != 0) begin
      in_valid <= 1'b0;
      repeat ((gap_mode == 1) ? $urandom_range(1, 3) : $urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // waits for the filter to drain and any gain recompute to finish before the write
  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [COEF_WIDTH-1:0] val);
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    in_t                   s;
    logic [COEF_WIDTH-1:0] fc;
    logic [COEF_WIDTH-1:0] res;
    int                    pick;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset coefficients: full-scale steps, silence, square wave, smallest codes
    for (int i = 0; i < DIRECTED_ITEMS; i++) begin
      if (i < 6) s.sample_in = SAMPLE_MAX;
      else if (i < 12) s.sample_in = SAMPLE_MIN;
      else if (i < 14) s.sample_in = '0;
      else if (i < 20) s.sample_in = i[0] ? SAMPLE_MAX : SAMPLE_MIN;
      else s.sample_in = i[0] ? SAMPLE_WIDTH'(1) : '1;
      s.block_last = (i % 5 == 4);
      push_sample(s);
    end
    in_valid <= 1'b0;

    for (int p = 1; p <= PHASES; p++) begin
      if (p <= 5) begin
        fc = CUTOFF_STEPS[p-1];
        res = RESONANCE_STEPS[p-1];
      end else begin
        fc = ($urandom_range(0, 3) == 0) ? COEF_WIDTH'($urandom()) :
                                            COEF_WIDTH'($urandom_range(0, 64880));
        res = ($urandom_range(0, 3) == 0) ? COEF_WIDTH'($urandom()) :
                                             COEF_WIDTH'($urandom_range(0, 57672));
      end
      if (p[0]) begin
        write_reg(REG_CUTOFF, fc);
        write_reg(REG_RESONANCE, res);
      end else begin
        write_reg(REG_RESONANCE, res);
        write_reg(REG_CUTOFF, fc);
      end
      // writes to unknown indexes must leave the coefficients alone
      if (p == 3) begin
        write_reg(REG_UNUSED_TOP, '1);
        write_reg(REG_UNUSED_FIRST, '0);
      end else if (p > 5) begin
        write_reg(CFG_INDEX_WIDTH'($urandom_range(2, 255)), COEF_WIDTH'($urandom()));
      end
      gap_mode = p % 3;
      stall_mode <= (p / 3) % 3;
      burst_left = 0;

      // held runs make steps that ring the resonance, mixed with full scale and noise
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 9);
        if (pick == 6) s.sample_in = SAMPLE_MAX;
        else if (pick == 7) s.sample_in = SAMPLE_MIN;
        else if (pick > 7) s.sample_in = SAMPLE_WIDTH'($urandom());
        s.block_last = ($urandom_range(0, 7) == 0);
        push_sample(s);
      end
      in_valid <= 1'b0;
    end

    do @(posedge clk); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== resonant_two_pole_lowpass.f =====
rtl/core/rtpl_pkg.sv
rtl/core/rtpl_coef.sv
rtl/core/rtpl_ctrl.sv
rtl/core/rtpl_datapath.sv
rtl/core/resonant_two_pole_lowpass.sv
sim/resonant_two_pole_lowpass_checker.sv
sim/resonant_two_pole_lowpass_tb.sv
